/* rtl/core/hba_pkg.sv */
package hba_pkg;

   // field widths of the request, response and csr beats
   localparam int BlockW  = 12;
   localparam int VolumeW = 13;
   localparam int OpW     = 2;
   localparam int CodeW   = 2;

   typedef logic [BlockW-1:0]  block_type;
   typedef logic [VolumeW-1:0] volume_type;
   typedef logic [OpW-1:0]     op_type;
   typedef logic [CodeW-1:0]   code_type;

   // operation codes
   localparam op_type OP_ALLOCATE = 2'd0;
   localparam op_type OP_FREE     = 2'd1;
   localparam op_type OP_STATUS   = 2'd2;

   // result codes
   localparam code_type RC_OK    = 2'd0;
   localparam code_type RC_FULL  = 2'd1;
   localparam code_type RC_RANGE = 2'd2;

   // volume size after reset
   localparam volume_type VolumeReset = 13'd4096;

   // fixed-point reciprocal used to split a block index into base-FANOUT digits
   localparam int RecipShift = 24;
   localparam int RecipW     = 22;
   localparam int ProdW      = BlockW + RecipW;

endpackage

/* rtl/core/hba_ram.sv */
module hba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one read port with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* rtl/core/hierarchical_bitmap_allocator.sv */
// Allocate: read and evaluate per level down, mark per level up, then load the response;
//   a full tree answers early with RC_FULL.
// Free and status: multiply and fix per digit, read and evaluate per level visited, then load;
//   rejects go straight to the response. One request at a time: the next is accepted
//   the cycle after the response is loaded.
// Reset (synchronous): clearing pass over every word of the tree, csr taken.
module hierarchical_bitmap_allocator
   import hba_pkg::*;
#(
   parameter int FANOUT = 16,
   parameter int LEVELS = 3
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  op_type     req_operation,
   input  block_type  req_block,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output code_type   rsp_result_code,
   output block_type  rsp_granted_block,
   output logic       rsp_block_used,
   // csr write port
   input  logic       csr_wr_en,
   input  volume_type csr_wr_data
);

   // tree geometry
   localparam int Total = 1 + ((LEVELS >= 2) ? FANOUT : 0)
                            + ((LEVELS >= 3) ? FANOUT * FANOUT : 0)
                            + ((LEVELS >= 4) ? FANOUT * FANOUT * FANOUT : 0);
   localparam int Capacity = FANOUT ** LEVELS;
   localparam int AW  = (Total > 1) ? $clog2(Total) : 1;
   localparam int BW  = $clog2(FANOUT);
   localparam int LVW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   localparam logic [AW-1:0]     LastAddr = AW'(Total - 1);
   localparam logic [LVW-1:0]    LastLvl  = LVW'(LEVELS - 1);
   localparam volume_type        CapLimit = VolumeW'((Capacity > 8191) ? 8191 : Capacity);
   localparam logic [RecipW-1:0] Recip    = RecipW'((1 << RecipShift) / FANOUT);
   localparam block_type         FanBlk   = BlockW'(FANOUT);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV_MUL,
      S_DIV_FIX,
      S_READ,
      S_EVAL,
      S_MARK,
      S_RESP
   } state_type;

   // first word of level t, top level is t = 0
   function automatic int base_of(input int t);
      int base;
      int span;
      base = 0;
      span = 1;
      for (int k = 0; k < 3; k++) begin
         if (k < t) begin
            base = base + span;
            span = span * FANOUT;
         end
      end
      return base;
   endfunction

   state_type state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [LVW-1:0]    lvl_ff, lvl_in;
   op_type            op_ff, op_in;
   volume_type        volume_ff, volume_in;
   logic [AW-1:0]     w_ff [LEVELS];
   logic [AW-1:0]     w_in [LEVELS];
   logic [BW-1:0]     b_ff [LEVELS];
   logic [BW-1:0]     b_in [LEVELS];
   logic [FANOUT-1:0] word_ff [LEVELS];
   logic [FANOUT-1:0] word_in [LEVELS];
   block_type         x_ff, x_in;
   logic [ProdW-1:0]  prod_ff, prod_in;
   code_type          res_code_ff, res_code_in;
   block_type         res_granted_ff, res_granted_in;
   logic              res_used_ff, res_used_in;
   logic              rsp_valid_ff, rsp_valid_in;
   code_type          rsp_code_ff, rsp_code_in;
   block_type         rsp_granted_ff, rsp_granted_in;
   logic              rsp_used_ff, rsp_used_in;

   // word RAM
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [FANOUT-1:0] ram_wdata;
   logic [FANOUT-1:0] ram_rdata;
   logic [AW-1:0]     cur_addr;

   // current level helpers
   logic [AW-1:0]     w_cur;
   logic [BW-1:0]     b_cur;
   logic [FANOUT-1:0] bit_mask;
   logic [BW-1:0]     low_zero;
   logic [FANOUT-1:0] marked;
   logic              out_range;
   logic [31:0]       next_idx;
   logic [31:0]       grant_idx;

   // digit split
   block_type         q_est;
   block_type         q_mul;
   block_type         rem;
   block_type         q_fix;
   block_type         r_fix;

   hba_ram #(
      .WIDTH (FANOUT),
      .DEPTH (Total)
   ) u_words (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cur_addr),
      .rd_data (ram_rdata)
   );

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_code   = rsp_code_ff;
   assign rsp_granted_block = rsp_granted_ff;
   assign rsp_block_used    = rsp_used_ff;

   // address and bit of the word at the current level
   assign w_cur    = w_ff[lvl_ff];
   assign b_cur    = b_ff[lvl_ff];
   assign cur_addr = AW'(base_of(int'(lvl_ff))) + w_cur;
   assign bit_mask = FANOUT'(1) << b_cur;
   assign marked   = word_ff[lvl_ff] | bit_mask;
   assign next_idx = 32'(w_cur) * 32'(FANOUT) + 32'(low_zero);
   assign grant_idx = 32'(w_ff[LEVELS-1]) * 32'(FANOUT) + 32'(b_ff[LEVELS-1]);
   assign out_range = ({1'b0, req_block} >= volume_ff) || ({1'b0, req_block} >= CapLimit);

   // lowest clear bit of the word just read
   always_comb begin
      low_zero = '0;
      for (int i = FANOUT - 1; i >= 0; i--) begin
         if (!ram_rdata[i]) begin
            low_zero = BW'(i);
         end
      end
   end

   // divide by FANOUT: reciprocal estimate is exact or one short
   always_comb begin
      q_est = BlockW'(prod_ff[ProdW-1:RecipShift]);
      q_mul = BlockW'(32'(q_est) * 32'(FANOUT));
      rem   = x_ff - q_mul;
      if (rem >= FanBlk) begin
         q_fix = q_est + BlockW'(1);
         r_fix = rem - FanBlk;
      end else begin
         q_fix = q_est;
         r_fix = rem;
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      lvl_in         = lvl_ff;
      op_in          = op_ff;
      volume_in      = csr_wr_en ? csr_wr_data : volume_ff;
      w_in           = w_ff;
      b_in           = b_ff;
      word_in        = word_ff;
      x_in           = x_ff;
      prod_in        = prod_ff;
      res_code_in    = res_code_ff;
      res_granted_in = res_granted_ff;
      res_used_in    = res_used_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_code_in    = rsp_code_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_used_in    = rsp_used_ff;
      ram_we         = 1'b0;
      ram_waddr      = cur_addr;
      ram_wdata      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            if (clr_ff == LastAddr) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               op_in          = req_operation;
               res_code_in    = RC_OK;
               res_granted_in = '0;
               res_used_in    = 1'b0;
               priority if (req_operation == OP_ALLOCATE) begin
                  lvl_in   = '0;
                  w_in[0]  = '0;
                  state_in = S_READ;
               end else if ((req_operation != OP_FREE && req_operation != OP_STATUS)
                            || out_range) begin
                  res_code_in = RC_RANGE;
                  state_in    = S_RESP;
               end else if (LEVELS > 1) begin
                  x_in     = req_block;
                  lvl_in   = LastLvl;
                  state_in = S_DIV_MUL;
               end else begin
                  b_in[0]  = BW'(req_block);
                  w_in[0]  = '0;
                  lvl_in   = '0;
                  state_in = S_READ;
               end
            end
         end

         S_DIV_MUL: begin
            prod_in  = ProdW'(x_ff) * ProdW'(Recip);
            state_in = S_DIV_FIX;
         end

         // one digit per pass, leaf level first
         S_DIV_FIX: begin
            w_in[lvl_ff] = AW'(q_fix);
            b_in[lvl_ff] = BW'(r_fix);
            x_in         = q_fix;
            if (lvl_ff == LVW'(1)) begin
               b_in[0]  = BW'(q_fix);
               w_in[0]  = '0;
               lvl_in   = LastLvl;
               state_in = S_READ;
            end else begin
               lvl_in   = lvl_ff - LVW'(1);
               state_in = S_DIV_MUL;
            end
         end

         S_READ: begin
            state_in = S_EVAL;
         end

         S_EVAL: begin
            priority if (op_ff == OP_ALLOCATE) begin
               if (&ram_rdata) begin
                  res_code_in = RC_FULL;
                  state_in    = S_RESP;
               end else begin
                  word_in[lvl_ff] = ram_rdata;
                  b_in[lvl_ff]    = low_zero;
                  if (lvl_ff == LastLvl) begin
                     state_in = S_MARK;
                  end else begin
                     w_in[lvl_ff + LVW'(1)] = AW'(next_idx);
                     lvl_in   = lvl_ff + LVW'(1);
                     state_in = S_READ;
                  end
               end
            end else if (op_ff == OP_FREE) begin
               // leaf always cleared; parents until one is already clear
               if (lvl_ff == LastLvl || ram_rdata[b_cur]) begin
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata & ~bit_mask;
                  if (lvl_ff == '0) begin
                     state_in = S_RESP;
                  end else begin
                     lvl_in   = lvl_ff - LVW'(1);
                     state_in = S_READ;
                  end
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               res_used_in = ram_rdata[b_cur];
               state_in    = S_RESP;
            end
         end

         // set the chosen bit, walk up while the word is full
         S_MARK: begin
            ram_we    = 1'b1;
            ram_wdata = marked;
            if ((&marked) && lvl_ff != '0) begin
               lvl_in = lvl_ff - LVW'(1);
            end else begin
               res_granted_in = grant_idx[BlockW-1:0];
               state_in       = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_code_in    = res_code_ff;
               rsp_granted_in = res_granted_ff;
               rsp_used_in    = res_used_ff;
               state_in       = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         volume_ff    <= VolumeReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         volume_ff    <= volume_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lvl_ff         <= lvl_in;
      op_ff          <= op_in;
      w_ff           <= w_in;
      b_ff           <= b_in;
      word_ff        <= word_in;
      x_ff           <= x_in;
      prod_ff        <= prod_in;
      res_code_ff    <= res_code_in;
      res_granted_ff <= res_granted_in;
      res_used_ff    <= res_used_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_used_ff    <= rsp_used_in;
   end

`ifndef SYNTHESIS
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> req_stall)
      else $error("request taken during clearing pass");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_RESP) |-> !ram_we)
      else $error("bitmap written outside an operation");

   a_fail_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_code != RC_OK |-> rsp_granted_block == '0 && !rsp_block_used)
      else $error("failed response carries data");

   a_used_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_used |-> rsp_granted_block == '0)
      else $error("status response carries a grant");
`endif

endmodule
